// File: rtl/core/uart_idle_timeout_framer_assert.svh
// assertion macros used by the checker file
`ifndef UART_IDLE_TIMEOUT_FRAMER_ASSERT_SVH
`define UART_IDLE_TIMEOUT_FRAMER_ASSERT_SVH

// property holds at every rising clock edge outside reset
`define UITF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("uitf assertion failed");

// condition in one cycle implies a condition in the next
`define UITF_ASSERT_NEXT(lbl, clk, rst, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) \
    else $error("uitf assertion failed");

`endif

// File: rtl/core/uitf_pkg.sv
package uitf_pkg;

  typedef enum logic [1:0] {
    ACT_RX   = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd5;
  localparam logic [7:0] IDLE_SAT         = 8'd255;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] tick_ms;
    logic [9:0] read_index;
    logic       read_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_valid;
    logic [10:0] byte_count;
    logic        frame_ready;
    logic        byte_dropped;
  } out_item_t;

  // result fields known at acceptance, before the store read returns
  typedef struct packed {
    logic        read_valid;
    logic [10:0] byte_count;
    logic        frame_ready;
    logic        byte_dropped;
  } meta_t;

endpackage

// File: rtl/core/uitf_in_if.sv
interface uitf_in_if;
  logic               valid;
  logic               ready;
  uitf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/uitf_out_if.sv
interface uitf_out_if;
  logic                valid;
  logic                ready;
  uitf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/uitf_ram.sv
module uitf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/uitf_ctrl.sv
module uitf_ctrl #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  uitf_pkg::in_item_t           item,
  input  logic                         cfg_wr_en,
  input  logic [7:0]                   cfg_wr_data,
  output uitf_pkg::meta_t              meta,
  output logic                         ram_we,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(BUF_DEPTH)-1:0] ram_raddr
);

  localparam int AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int EXT_W = (CNT_W > 11) ? CNT_W : 11;

  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] count_snapshot, count_snapshot_next;
  logic [7:0]       idle_time, idle_time_next;
  logic             frame_flag, frame_flag_next;
  logic [7:0]       idle_limit;

  logic [8:0]       idle_sum;
  logic [7:0]       idle_sat;
  logic [EXT_W-1:0] idx_ext;
  logic [EXT_W-1:0] held_ext;
  logic [EXT_W-1:0] count_ext;
  logic             idx_ok;
  logic             clear;

  always_comb begin
    idx_ext  = EXT_W'(item.read_index);
    held_ext = EXT_W'(held_count);
    idx_ok   = (idx_ext < held_ext) && (idx_ext < EXT_W'(BUF_DEPTH));
    idle_sum = {1'b0, idle_time} + {1'b0, item.tick_ms};
    idle_sat = idle_sum[8] ? uitf_pkg::IDLE_SAT : idle_sum[7:0];

    held_count_next     = held_count;
    count_snapshot_next = count_snapshot;
    idle_time_next      = idle_time;
    frame_flag_next     = frame_flag;
    clear               = 1'b0;

    ram_we    = 1'b0;
    ram_waddr = held_count[AW-1:0];
    ram_wdata = item.rx_byte;
    ram_re    = 1'b0;
    ram_raddr = idx_ext[AW-1:0];

    meta.read_valid   = 1'b0;
    meta.byte_dropped = 1'b0;

    case (uitf_pkg::action_t'(item.action))
      uitf_pkg::ACT_RX: begin
        if (held_count != CNT_W'(BUF_DEPTH)) begin
          ram_we          = accept;
          held_count_next = held_count + CNT_W'(1);
        end else begin
          meta.byte_dropped = 1'b1;
        end
      end
      uitf_pkg::ACT_TICK: begin
        if (held_count != '0) begin
          if (count_snapshot != held_count) begin
            count_snapshot_next = held_count;
            idle_time_next      = '0;
          end else if (idle_time < idle_limit) begin
            idle_time_next = idle_sat;
            if (idle_sat >= idle_limit) begin
              frame_flag_next = 1'b1;
            end
          end
        end else begin
          count_snapshot_next = '0;
        end
      end
      uitf_pkg::ACT_READ: begin
        meta.read_valid = idx_ok;
        ram_re          = accept && idx_ok;
        clear           = item.read_last;
      end
      default: begin
      end
    endcase

    // reported values are taken before the end-of-read clear
    count_ext        = EXT_W'(held_count_next);
    meta.byte_count  = count_ext[10:0];
    meta.frame_ready = frame_flag_next;

    if (clear) begin
      held_count_next = '0;
      frame_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      count_snapshot <= '0;
      idle_time      <= '0;
      frame_flag     <= 1'b0;
      idle_limit     <= uitf_pkg::IDLE_LIMIT_RESET;
    end else begin
      if (accept) begin
        held_count     <= held_count_next;
        count_snapshot <= count_snapshot_next;
        idle_time      <= idle_time_next;
        frame_flag     <= frame_flag_next;
      end
      if (cfg_wr_en) begin
        idle_limit <= cfg_wr_data;
      end
    end
  end

endmodule

// File: rtl/core/uart_idle_timeout_framer.sv
// uart idle-timeout framer
// items channel: one transaction per event - a received byte, a timer tick
// carrying the milliseconds elapsed, or a read of a buffered byte by index
// (read_last on the final read clears the byte count and the frame flag)
// results channel: exactly one transaction per item, in order, giving the
// read byte and its valid flag, the byte count and frame flag after the
// item (before any end-of-read clear) and a drop flag for a full buffer
// cfg_wr_en/cfg_wr_data: writes idle_limit_ms, taken at any edge with
// cfg_wr_en high; it should only change while no item is in flight
// throughput: one item per cycle while the output path has room; the byte
// buffer is a single ram with one write and one registered read port, and each
// item needs at most one of them; an accepted item's result passes the ram
// read stage (s1), then the output register (s2)
// the two-entry output path lets a new item be accepted while a finished
// result waits; items stop only when both entries are held by a stalled
// receiver
// reset clears count, snapshot, idle time, frame flag and restores the idle
// limit to 5; the byte buffer needs no clearing since only written bytes
// are ever read
module uart_idle_timeout_framer #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  uitf_in_if.sink          items,
  uitf_out_if.source       results,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic                accept;
  uitf_pkg::meta_t     meta;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [7:0]          ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [7:0]          ram_rdata;

  logic                s1_valid;
  uitf_pkg::meta_t     s1_meta;
  logic                s2_valid;
  uitf_pkg::out_item_t s2_item;
  logic                advance;

  assign advance     = s1_valid && (!s2_valid || results.ready);
  assign items.ready = !s1_valid || advance;
  assign accept      = items.valid && items.ready;

  uitf_ctrl #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (items.data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .meta       (meta),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  // read data holds while s1 waits, since reads issue only on acceptance
  uitf_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        s2_valid <= 1'b1;
      end else if (results.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
    if (advance) begin
      s2_item.read_data    <= s1_meta.read_valid ? ram_rdata : 8'd0;
      s2_item.read_valid   <= s1_meta.read_valid;
      s2_item.byte_count   <= s1_meta.byte_count;
      s2_item.frame_ready  <= s1_meta.frame_ready;
      s2_item.byte_dropped <= s1_meta.byte_dropped;
    end
  end

  assign results.valid = s2_valid;
  assign results.data  = s2_item;

endmodule

// File: rtl/core/uitf_checker.sv
`include "uart_idle_timeout_framer_assert.svh"

module uitf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  read_data,
  input logic        read_valid,
  input logic [10:0] byte_count,
  input logic        byte_dropped
);

  // a valid read needs at least one buffered byte
  `UITF_ASSERT(a_read_needs_count, clk, rst, (out_valid && read_valid) |-> (byte_count != 11'd0))

  `UITF_ASSERT(a_invalid_read_zero, clk, rst, (out_valid && !read_valid) |-> (read_data == 8'd0))

  // a dropped byte belongs to a receive, never to a read
  `UITF_ASSERT(a_drop_not_read, clk, rst, (out_valid && byte_dropped) |-> !read_valid)

  `UITF_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)

endmodule

bind uart_idle_timeout_framer uitf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .read_data   (results.data.read_data),
  .read_valid  (results.data.read_valid),
  .byte_count  (results.data.byte_count),
  .byte_dropped(results.data.byte_dropped)
);

// File: tb/testbench.sv
module testbench;

  localparam int STORE_DEPTH = 1024;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  uitf_in_if  items_if ();
  uitf_out_if results_if ();

  uart_idle_timeout_framer #(.BUF_DEPTH(STORE_DEPTH)) DUT (
    .clk         (clk),
    .rst         (rst),
    .items       (items_if),
    .results     (results_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  // predictor copy of the framer state
  logic [7:0]  rx_mem [STORE_DEPTH];
  logic [10:0] held_count = '0;
  logic [10:0] count_snapshot = '0;
  logic [7:0]  idle_time = '0;
  logic        frame_flag = 1'b0;
  logic [7:0]  idle_limit = uitf_pkg::IDLE_LIMIT_RESET;

  int in_idle_pct;
  int out_idle_pct;
  int mismatch_count = 0;
  int events_sent = 0;

  uitf_pkg::out_item_t awaited_status_q[$];

  function automatic uitf_pkg::out_item_t predict_framer_status(input uitf_pkg::in_item_t it);
    uitf_pkg::out_item_t r;
    int                  sum;
    logic                clear_after;
    r = '0;
    clear_after = 1'b0;
    case (it.action)
      uitf_pkg::ACT_RX: begin
        if (held_count < STORE_DEPTH) begin
          rx_mem[held_count[9:0]] = it.rx_byte;
          held_count = held_count + 11'd1;
        end else begin
          r.byte_dropped = 1'b1;
        end
      end
      uitf_pkg::ACT_TICK: begin
        if (held_count != 0) begin
          if (count_snapshot != held_count) begin
            count_snapshot = held_count;
            idle_time = '0;
          end else if (idle_time < idle_limit) begin
            sum = int'(idle_time) + int'(it.tick_ms);
            idle_time = (sum > int'(uitf_pkg::IDLE_SAT)) ? uitf_pkg::IDLE_SAT : 8'(sum);
            if (idle_time >= idle_limit) frame_flag = 1'b1;
          end
        end else begin
          count_snapshot = '0;
        end
      end
      uitf_pkg::ACT_READ: begin
        if (it.read_index < held_count) begin
          r.read_valid = 1'b1;
          r.read_data = rx_mem[it.read_index];
        end
        clear_after = it.read_last;
      end
      default: ;
    endcase
    // count and flag are reported before an end-of-read clear
    r.byte_count = held_count;
    r.frame_ready = frame_flag;
    if (clear_after) begin
      held_count = '0;
      frame_flag = 1'b0;
    end
    return r;
  endfunction

  function automatic uitf_pkg::in_item_t mk_event(input logic [1:0] act, input logic [7:0] b,
                                                  input logic [7:0] t, input logic [9:0] idx,
                                                  input logic last);
    uitf_pkg::in_item_t it;
    it.action = act;
    it.rx_byte = b;
    it.tick_ms = t;
    it.read_index = idx;
    it.read_last = last;
    return it;
  endfunction

  task automatic send_item(input uitf_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid <= 1'b1;
    items_if.data <= it;
    do @(posedge clk); while (!items_if.ready);
    awaited_status_q.push_back(predict_framer_status(it));
    if (it.action != ACT_UNUSED) events_sent++;
  endtask

  // fields that the action does not use carry random values
  task automatic send_rx(input logic [7:0] b);
    send_item(mk_event(uitf_pkg::ACT_RX, b, 8'($urandom), 10'($urandom), 1'($urandom)));
  endtask

  task automatic send_tick(input logic [7:0] t);
    send_item(mk_event(uitf_pkg::ACT_TICK, 8'($urandom), t, 10'($urandom), 1'($urandom)));
  endtask

  task automatic send_read(input logic [9:0] idx, input logic last);
    send_item(mk_event(uitf_pkg::ACT_READ, 8'($urandom), 8'($urandom), idx, last));
  endtask

  task automatic send_unused();
    send_item(mk_event(ACT_UNUSED, 8'($urandom), 8'($urandom), 10'($urandom),
                       1'($urandom)));
  endtask

  task automatic wait_status_drained();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (awaited_status_q.size() != 0) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic set_idle_limit(input logic [7:0] v);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    idle_limit = v;
  endtask

  task automatic test_directed();
    send_tick(8'd10);
    send_read(10'd0, 1'b1);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'hA5);
    send_tick(8'd0);
    send_tick(8'd0);
    send_tick(8'd3);
    send_tick(8'd2);
    // byte after a completed frame, then the idle time restarts
    send_rx(8'h5A);
    send_tick(8'd255);
    send_tick(8'd255);
    send_unused();
    send_read(10'd1023, 1'b0);
    send_read(10'd0, 1'b0);
    send_read(10'd3, 1'b0);
    send_read(10'd2, 1'b1);
    send_read(10'd0, 1'b0);
    wait_status_drained();
    // a zero limit never completes a frame
    set_idle_limit(8'd0);
    send_rx(8'($urandom));
    send_tick(8'd1);
    send_tick(8'd255);
    send_tick(8'd255);
    send_read(10'd0, 1'b1);
    wait_status_drained();
  endtask

  task automatic test_full_store();
    set_idle_limit(8'd1);
    repeat (STORE_DEPTH) send_rx(8'($urandom));
    send_rx(8'($urandom));
    send_rx(8'($urandom));
    send_tick(8'd0);
    send_tick(8'd1);
    send_read(10'd1023, 1'b0);
    send_read(10'd0, 1'b1);
    wait_status_drained();
  endtask

  task automatic test_random_frames(input int n_events, input int src_pct, input int dst_pct,
                                    input logic [7:0] limit);
    int target;
    int nb;
    int reads;
    int n_ticks;
    wait_status_drained();
    in_idle_pct = src_pct;
    out_idle_pct = dst_pct;
    set_idle_limit(limit);
    target = events_sent + n_events;
    while (events_sent < target) begin
      if ($urandom_range(99) < 80) begin
        nb = ($urandom_range(19) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        repeat (nb) send_rx(8'($urandom));
        n_ticks = 0;
        while (!frame_flag && n_ticks < 40) begin
          // a stray byte now and then breaks the silence
          if ($urandom_range(19) == 0) send_rx(8'($urandom));
          send_tick(8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(8)));
          n_ticks++;
        end
        reads = $urandom_range(int'(held_count), 1);
        for (int i = 1; i <= reads; i++)
          send_read(10'($urandom_range(int'(held_count) - 1)), i == reads);
        if ($urandom_range(11) == 0) wait_status_drained();
      end else begin
        case ($urandom_range(3))
          0: send_read(10'($urandom_range(STORE_DEPTH - 1)), $urandom_range(9) == 0);
          1: send_tick(8'($urandom));
          2: send_rx(8'($urandom));
          default: send_unused();
        endcase
      end
    end
    wait_status_drained();
  endtask

  task automatic check_field(input string fname, input logic [10:0] want,
                             input logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(negedge clk) begin
    results_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    uitf_pkg::out_item_t want;
    if (!rst && results_if.valid && results_if.ready) begin
      if (awaited_status_q.size() == 0) begin
        $display("%0t: expected no transaction, actual %p", $time, results_if.data);
        mismatch_count++;
      end else begin
        want = awaited_status_q.pop_front();
        check_field("read_data", 11'(want.read_data), 11'(results_if.data.read_data));
        check_field("read_valid", 11'(want.read_valid), 11'(results_if.data.read_valid));
        check_field("byte_count", want.byte_count, results_if.data.byte_count);
        check_field("frame_ready", 11'(want.frame_ready),
                    11'(results_if.data.frame_ready));
        check_field("byte_dropped", 11'(want.byte_dropped),
                    11'(results_if.data.byte_dropped));
      end
    end
  end

  initial begin
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.data = '0;
    results_if.ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_idle_pct = 7;
    out_idle_pct = 72;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_store();
    test_random_frames(270, 7, 72, 8'($urandom_range(20, 2)));
    test_random_frames(270, 72, 7, 8'd255);
    test_random_frames(260, 0, 0, 8'd1);
    wait_status_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
